/* rtl/anfd_pkg.sv */
// Shared constants, types and the character pair decode for the ASCII nibble frame decoder.
package anfd_pkg;

   // Operation codes of an input item.
   localparam logic OP_CHAR  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [7:0] DIGIT_BASE  = 8'h30;
   localparam logic [4:0] FRAME_CHARS = 5'd20;
   localparam int         DATA_BYTES  = 9;
   localparam int         TEMP_COUNT  = 8;
   localparam int         IDX_W       = $clog2(DATA_BYTES + 1);
   localparam logic [IDX_W-1:0] CHECKSUM_IDX = IDX_W'(DATA_BYTES);

   typedef struct packed {
      logic [TEMP_COUNT-1:0][7:0] temp;
      logic [7:0]                 status_byte;
      logic                       frame_error;
   } frame_result_type;

   // High digit keeps its low nibble after the shift; low digit is ORed in whole.
   function automatic logic [7:0] pair_decode(input logic [7:0] hi, input logic [7:0] lo);
      logic [7:0] h;
      logic [7:0] l;
      h = hi - DIGIT_BASE;
      l = lo - DIGIT_BASE;
      return {h[3:0], 4'b0000} | l;
   endfunction

endpackage

/* rtl/anfd_assembler.sv */
// Frame state: character position, held high character, decoded bytes and running checksum.
module anfd_assembler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic                       operation,
   input  logic [7:0]                 rx_char,
   output logic                       completes,
   output anfd_pkg::frame_result_type result
);

   logic [4:0] pos_ff, pos_in;
   logic [7:0] hold_ff, hold_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] byte_ff [anfd_pkg::DATA_BYTES];

   logic [4:0]                  pos_eff;
   logic [anfd_pkg::IDX_W-1:0]  idx;
   logic [7:0]                  decoded;
   logic                        write_byte;
   logic                        err;

   // Wrap an out-of-range position back to the frame start.
   assign pos_eff = (pos_ff >= anfd_pkg::FRAME_CHARS) ? 5'd0 : pos_ff;
   assign idx     = pos_eff[4:1];
   assign decoded = anfd_pkg::pair_decode(hold_ff, rx_char);

   assign completes  = (operation == anfd_pkg::OP_CHAR) && pos_eff[0]
                       && (idx == anfd_pkg::CHECKSUM_IDX);
   assign write_byte = step && (operation == anfd_pkg::OP_CHAR) && pos_eff[0]
                       && (idx < anfd_pkg::CHECKSUM_IDX);

   always_comb begin
      pos_in  = pos_ff;
      hold_in = hold_ff;
      sum_in  = sum_ff;
      if (step) begin
         if (operation == anfd_pkg::OP_FLUSH) begin
            pos_in = 5'd0;
            sum_in = 8'd0;
         end else if (!pos_eff[0]) begin
            hold_in = rx_char;
            pos_in  = pos_eff + 5'd1;
         end else if (idx < anfd_pkg::CHECKSUM_IDX) begin
            sum_in = sum_ff + decoded;
            pos_in = pos_eff + 5'd1;
         end else begin
            pos_in = 5'd0;
            sum_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 5'd0;
         hold_ff <= 8'd0;
         sum_ff  <= 8'd0;
      end else begin
         pos_ff  <= pos_in;
         hold_ff <= hold_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_byte) begin
         byte_ff[idx] <= decoded;
      end
   end

   // Zero every value on a checksum mismatch.
   assign err = (sum_ff != decoded);
   always_comb begin
      for (int k = 0; k < anfd_pkg::TEMP_COUNT; k++) begin
         result.temp[k] = err ? 8'd0 : byte_ff[k];
      end
      result.status_byte = err ? 8'd0 : byte_ff[anfd_pkg::DATA_BYTES-1];
      result.frame_error = err;
   end

endmodule

/* rtl/ascii_nibble_frame_decoder.sv */
// Top level of the ASCII nibble frame decoder: input register, frame assembler, result register.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   req     | in        | req_valid/req_stall  | req_operation, req_rx_char
//   rsp     | out       | rsp_valid/rsp_stall  | rsp_temp_0..7, rsp_status_byte,
//           |           |                      | rsp_frame_error
//
// One item per cycle is sustained while no result waits under rsp_stall. An item
// is held in the input register, where the assembler decodes it and updates the
// frame state; the twentieth character of a frame loads the result register as it
// leaves the input register, so rsp_valid rises from the result register.
// Reset (synchronous, active high) empties both registers and returns to frame start.
// A stalled result holds the completing character in the input register; every
// other item keeps flowing, so req_stall rises only while a result waits under rsp_stall.
module ascii_nibble_frame_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   input  logic [7:0]        req_rx_char,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [7:0] rsp_temp_0,
   output logic signed [7:0] rsp_temp_1,
   output logic signed [7:0] rsp_temp_2,
   output logic signed [7:0] rsp_temp_3,
   output logic signed [7:0] rsp_temp_4,
   output logic signed [7:0] rsp_temp_5,
   output logic signed [7:0] rsp_temp_6,
   output logic signed [7:0] rsp_temp_7,
   output logic [7:0]        rsp_status_byte,
   output logic              rsp_frame_error
);

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic       in_op_ff;
   logic [7:0] in_char_ff;

   // Result register.
   logic                       rsp_valid_ff, rsp_valid_in;
   anfd_pkg::frame_result_type rsp_ff;

   logic                       completes;
   anfd_pkg::frame_result_type result;
   logic                       advance;
   logic                       accept;
   logic                       load_rsp;

   anfd_assembler u_assembler (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .operation (in_op_ff),
      .rx_char   (in_char_ff),
      .completes (completes),
      .result    (result)
   );

   // Advance the held item unless it completes a frame and the result slot is blocked.
   assign advance   = in_valid_ff && (!completes || !rsp_valid_ff || !rsp_stall);
   assign load_rsp  = advance && completes;
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the payload only on accept.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff   <= req_operation;
         in_char_ff <= req_rx_char;
      end
   end

   // Hold the result while stalled; load a fresh one when the frame completes.
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temp_0      = $signed(rsp_ff.temp[0]);
   assign rsp_temp_1      = $signed(rsp_ff.temp[1]);
   assign rsp_temp_2      = $signed(rsp_ff.temp[2]);
   assign rsp_temp_3      = $signed(rsp_ff.temp[3]);
   assign rsp_temp_4      = $signed(rsp_ff.temp[4]);
   assign rsp_temp_5      = $signed(rsp_ff.temp[5]);
   assign rsp_temp_6      = $signed(rsp_ff.temp[6]);
   assign rsp_temp_7      = $signed(rsp_ff.temp[7]);
   assign rsp_status_byte = rsp_ff.status_byte;
   assign rsp_frame_error = rsp_ff.frame_error;

endmodule

/* rtl/anfd_checker.sv */
// Port-level checks for the ASCII nibble frame decoder, bound to the top level.
module anfd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic signed [7:0] rsp_temp_0,
   input logic signed [7:0] rsp_temp_1,
   input logic signed [7:0] rsp_temp_2,
   input logic signed [7:0] rsp_temp_3,
   input logic signed [7:0] rsp_temp_4,
   input logic signed [7:0] rsp_temp_5,
   input logic signed [7:0] rsp_temp_6,
   input logic signed [7:0] rsp_temp_7,
   input logic [7:0]        rsp_status_byte,
   input logic              rsp_frame_error
);

   // A waiting result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // A waiting result keeps its error flag, status byte and first and last temperatures.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_frame_error) && $stable(rsp_status_byte)
         && $stable(rsp_temp_0) && $stable(rsp_temp_7))
      else $error("result changed while stalled");

   // Backpressure on the input only comes from a blocked result.
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req_stall without result backpressure");

   // A checksum mismatch carries all-zero values.
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_error |-> rsp_status_byte == 8'd0
         && rsp_temp_0 == 8'sd0 && rsp_temp_1 == 8'sd0 && rsp_temp_2 == 8'sd0
         && rsp_temp_3 == 8'sd0 && rsp_temp_4 == 8'sd0 && rsp_temp_5 == 8'sd0
         && rsp_temp_6 == 8'sd0 && rsp_temp_7 == 8'sd0)
      else $error("nonzero values on a checksum mismatch");

endmodule

bind ascii_nibble_frame_decoder anfd_checker u_anfd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_temp_0      (rsp_temp_0),
   .rsp_temp_1      (rsp_temp_1),
   .rsp_temp_2      (rsp_temp_2),
   .rsp_temp_3      (rsp_temp_3),
   .rsp_temp_4      (rsp_temp_4),
   .rsp_temp_5      (rsp_temp_5),
   .rsp_temp_6      (rsp_temp_6),
   .rsp_temp_7      (rsp_temp_7),
   .rsp_status_byte (rsp_status_byte),
   .rsp_frame_error (rsp_frame_error)
);

/* dv/tb_top.sv */
// Self-checking testbench for the ASCII nibble frame decoder.
module tb_top;

   // One entry of the character feed. A directed row may carry its result typed in.
   typedef struct packed {
      logic                       op;
      logic [7:0]                 ch;
      logic                       fixed;
      anfd_pkg::frame_result_type want;
   } char_item_type;

   typedef enum int {FRAME_CLEAN, FRAME_BAD_SUM, FRAME_WIDE} frame_kind_type;

   localparam int QUIET_LIMIT    = 2000;  // cycles with no item moving on either side
   localparam int LONG_HOLD      = 80;    // receiver hold-off that backs up the block
   localparam int TAIL_CYCLES    = 4;     // idle tail after the feed and results drain
   localparam int PHASE_ITEMS    = 255;
   localparam int DIRECTED_COUNT = 23;

   localparam anfd_pkg::frame_result_type CSUM_FAIL =
      '{temp: '0, status_byte: 8'h00, frame_error: 1'b1};

   // Directed part: flush on an empty frame, flush in the middle of a pair, then one
   // frame of extreme characters whose checksum cannot match (nine 0xFF bytes sum to
   // 0xF7, the pair 0x00,0x00 decodes to 0xD0), so everything reads zero with the error.
   localparam char_item_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{anfd_pkg::OP_FLUSH, 8'hA5, 1'b0, '0},
      '{anfd_pkg::OP_CHAR,  8'h00, 1'b0, '0},
      '{anfd_pkg::OP_FLUSH, 8'hFF, 1'b0, '0},
      '{anfd_pkg::OP_CHAR,  8'hFF, 1'b0, '0}, '{anfd_pkg::OP_CHAR, 8'hFF, 1'b0, '0},
      '{anfd_pkg::OP_CHAR,  8'hFF, 1'b0, '0}, '{anfd_pkg::OP_CHAR, 8'hFF, 1'b0, '0},
      '{anfd_pkg::OP_CHAR,  8'hFF, 1'b0, '0}, '{anfd_pkg::OP_CHAR, 8'hFF, 1'b0, '0},
      '{anfd_pkg::OP_CHAR,  8'hFF, 1'b0, '0}, '{anfd_pkg::OP_CHAR, 8'hFF, 1'b0, '0},
      '{anfd_pkg::OP_CHAR,  8'hFF, 1'b0, '0}, '{anfd_pkg::OP_CHAR, 8'hFF, 1'b0, '0},
      '{anfd_pkg::OP_CHAR,  8'hFF, 1'b0, '0}, '{anfd_pkg::OP_CHAR, 8'hFF, 1'b0, '0},
      '{anfd_pkg::OP_CHAR,  8'hFF, 1'b0, '0}, '{anfd_pkg::OP_CHAR, 8'hFF, 1'b0, '0},
      '{anfd_pkg::OP_CHAR,  8'hFF, 1'b0, '0}, '{anfd_pkg::OP_CHAR, 8'hFF, 1'b0, '0},
      '{anfd_pkg::OP_CHAR,  8'hFF, 1'b0, '0}, '{anfd_pkg::OP_CHAR, 8'hFF, 1'b0, '0},
      '{anfd_pkg::OP_CHAR,  8'h00, 1'b0, '0},
      '{anfd_pkg::OP_CHAR,  8'h00, 1'b1, CSUM_FAIL}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_operation = anfd_pkg::OP_CHAR;
   logic [7:0]        req_rx_char = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [7:0] rsp_temp_0, rsp_temp_1, rsp_temp_2, rsp_temp_3;
   logic signed [7:0] rsp_temp_4, rsp_temp_5, rsp_temp_6, rsp_temp_7;
   logic [7:0]        rsp_status_byte;
   logic              rsp_frame_error;

   // Feed and scoreboard.
   char_item_type              char_feed[$];
   anfd_pkg::frame_result_type pending_frames[$];
   char_item_type              on_pins;
   int                         mismatch_count = 0;
   int                         fed_count = 0;
   int                         quiet_cycles = 0;

   // Idle control: percentages and hold request written by the sequence at the falling edge.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit long_hold_req = 1'b0;
   bit long_hold_done = 1'b0;
   int long_hold_left = 0;

   // Frame tracker state: position in the frame, held high char, decoded bytes, sum.
   logic [4:0] frame_pos = '0;
   logic [7:0] pair_high = '0;
   logic [7:0] frame_bytes [anfd_pkg::DATA_BYTES];
   logic [7:0] frame_sum = '0;

   always #1 clock = ~clock;

   ascii_nibble_frame_decoder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_rx_char     (req_rx_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_temp_0      (rsp_temp_0),
      .rsp_temp_1      (rsp_temp_1),
      .rsp_temp_2      (rsp_temp_2),
      .rsp_temp_3      (rsp_temp_3),
      .rsp_temp_4      (rsp_temp_4),
      .rsp_temp_5      (rsp_temp_5),
      .rsp_temp_6      (rsp_temp_6),
      .rsp_temp_7      (rsp_temp_7),
      .rsp_status_byte (rsp_status_byte),
      .rsp_frame_error (rsp_frame_error)
   );

   // Decode a character pair: the high digit wraps and keeps only its low nibble once
   // shifted up; the low digit wraps and is ORed in as a full byte.
   function automatic logic [7:0] pair_byte(input logic [7:0] hi, input logic [7:0] lo);
      logic [7:0] hi_digit;
      logic [7:0] lo_digit;
      hi_digit = hi - 8'h30;
      lo_digit = lo - 8'h30;
      hi_digit = hi_digit << 4;
      return hi_digit | lo_digit;
   endfunction

   // Advance the frame tracker by one accepted item; raise done on the closing char.
   task automatic track_char(input logic op, input logic [7:0] ch,
                             output bit done, output anfd_pkg::frame_result_type frame);
      logic [7:0] value;
      int         idx;
      int         k;
      done  = 1'b0;
      frame = '0;
      if (op == anfd_pkg::OP_FLUSH) begin
         // Drop the partial frame; nothing comes out.
         frame_pos = '0;
         frame_sum = '0;
      end else if (frame_pos[0] == 1'b0) begin
         pair_high = ch;
         frame_pos = frame_pos + 5'd1;
      end else begin
         value = pair_byte(pair_high, ch);
         idx   = int'(frame_pos[4:1]);
         if (idx < anfd_pkg::DATA_BYTES) begin
            frame_bytes[idx] = value;
            frame_sum        = frame_sum + value;
            frame_pos        = frame_pos + 5'd1;
         end else begin
            // Checksum pair closes the frame; a mismatch zeroes every value.
            done = 1'b1;
            if (frame_sum == value) begin
               for (k = 0; k < anfd_pkg::TEMP_COUNT; k++) frame.temp[k] = frame_bytes[k];
               frame.status_byte = frame_bytes[anfd_pkg::TEMP_COUNT];
            end else begin
               frame.frame_error = 1'b1;
            end
            frame_pos = '0;
            frame_sum = '0;
         end
      end
   endtask

   // Compare the result on the pins with the oldest pending frame, field by field.
   task automatic check_frame();
      anfd_pkg::frame_result_type want;
      logic [7:0]                 seen [anfd_pkg::TEMP_COUNT];
      int                         k;
      seen = '{rsp_temp_0, rsp_temp_1, rsp_temp_2, rsp_temp_3,
               rsp_temp_4, rsp_temp_5, rsp_temp_6, rsp_temp_7};
      if (pending_frames.size() == 0) begin
         $error("result with no frame pending");
         mismatch_count++;
         return;
      end
      want = pending_frames.pop_front();
      for (k = 0; k < anfd_pkg::TEMP_COUNT; k++) begin
         if (seen[k] !== want.temp[k]) begin
            $error("temp_%0d: expected %0d, got %0d", k, $signed(want.temp[k]),
                   $signed(seen[k]));
            mismatch_count++;
         end
      end
      if (rsp_status_byte !== want.status_byte) begin
         $error("status_byte: expected %0d, got %0d", want.status_byte, rsp_status_byte);
         mismatch_count++;
      end
      if (rsp_frame_error !== want.frame_error) begin
         $error("frame_error: expected %0d, got %0d", want.frame_error, rsp_frame_error);
         mismatch_count++;
      end
   endtask

   // Sender and scoreboard in one process so push and pop never race.
   always @(posedge clock) begin : feed_and_check
      bit                         done;
      anfd_pkg::frame_result_type frame;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // Track an item taken on this edge; a typed-in row overrides the prediction.
         if (req_valid && !req_stall) begin
            track_char(req_operation, req_rx_char, done, frame);
            if (done) pending_frames.push_back(on_pins.fixed ? on_pins.want : frame);
         end
         if (rsp_valid && !rsp_stall) check_frame();
         // Offer the next item only once the current one is gone; hold it otherwise.
         if (!req_valid || !req_stall) begin
            if (char_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_pins = char_feed.pop_front();
               req_valid     <= 1'b1;
               req_operation <= on_pins.op;
               req_rx_char   <= on_pins.ch;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stall, plus one long hold-off counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_left != 0) begin
         rsp_stall <= 1'b1;
         long_hold_left--;
      end else if (long_hold_req && !long_hold_done) begin
         long_hold_done = 1'b1;
         long_hold_left = LONG_HOLD - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_char(input logic op, input logic [7:0] ch);
      char_item_type item;
      item    = '0;
      item.op = op;
      item.ch = ch;
      char_feed.push_back(item);
      fed_count++;
   endtask

   // Queue one whole frame. Clean frames use characters 0x30 to 0x3F and a good checksum;
   // wide frames use any byte and get a good checksum half the time.
   task automatic queue_frame(input frame_kind_type kind);
      logic [7:0] hi;
      logic [7:0] lo;
      logic [7:0] total;
      logic [7:0] csum;
      int         k;
      total = '0;
      for (k = 0; k < anfd_pkg::DATA_BYTES; k++) begin
         if (kind == FRAME_WIDE) begin
            hi = 8'($urandom_range(255));
            lo = 8'($urandom_range(255));
         end else begin
            hi = 8'(anfd_pkg::DIGIT_BASE + $urandom_range(15));
            lo = 8'(anfd_pkg::DIGIT_BASE + $urandom_range(15));
         end
         total = total + pair_byte(hi, lo);
         queue_char(anfd_pkg::OP_CHAR, hi);
         queue_char(anfd_pkg::OP_CHAR, lo);
      end
      csum = total;
      if (kind == FRAME_BAD_SUM || (kind == FRAME_WIDE && $urandom_range(1) == 1))
         csum = total + 8'($urandom_range(1, 255));
      // High character of the checksum pair goes first.
      queue_char(anfd_pkg::OP_CHAR, anfd_pkg::DIGIT_BASE + {4'h0, csum[7:4]});
      queue_char(anfd_pkg::OP_CHAR, anfd_pkg::DIGIT_BASE + {4'h0, csum[3:0]});
   endtask

   // Queue a partial frame of arbitrary characters and drop it with a flush.
   task automatic queue_broken();
      int count;
      int k;
      count = $urandom_range(19);
      for (k = 0; k < count; k++) queue_char(anfd_pkg::OP_CHAR, 8'($urandom_range(255)));
      queue_char(anfd_pkg::OP_FLUSH, 8'($urandom_range(255)));
   endtask

   // Mostly well-formed frames, some with bad checksums or odd characters, some noise.
   task automatic queue_random(input int count);
      int stop_at;
      int pick;
      stop_at = fed_count + count;
      while (fed_count < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 60)      queue_frame(FRAME_CLEAN);
         else if (pick < 72) queue_frame(FRAME_BAD_SUM);
         else if (pick < 85) queue_frame(FRAME_WIDE);
         else                queue_broken();
      end
   endtask

   // Hold the sender until every queued item is in and every result is out.
   task automatic wait_drained();
      while (char_feed.size() != 0 || req_valid || pending_frames.size() != 0)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   initial begin
      int phase_send [4];
      int phase_stall [4];
      int phase;
      int k;
      phase_send  = '{0, 46, 0, 14};
      phase_stall = '{0, 0, 46, 14};
      for (k = 0; k < anfd_pkg::DATA_BYTES; k++) frame_bytes[k] = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table with no idling on either side.
      @(negedge clock);
      for (k = 0; k < DIRECTED_COUNT; k++) begin
         char_feed.push_back(DIRECTED_ROWS[k]);
         fed_count++;
      end
      wait_drained();

      // Idle phases: none, sender only, receiver only, both.
      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = phase_send[phase];
         rsp_stall_pct = phase_stall[phase];
         queue_random(PHASE_ITEMS);
         wait_drained();
         // Back the block up once: long receiver hold while the sender keeps going.
         if (phase == 0) begin
            long_hold_req = 1'b1;
            for (k = 0; k < 6; k++) queue_frame(FRAME_CLEAN);
            wait_drained();
         end
      end

      if (pending_frames.size() != 0) begin
         $error("%0d frames never came out", pending_frames.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/anfd_pkg.sv
rtl/anfd_assembler.sv
rtl/ascii_nibble_frame_decoder.sv
rtl/anfd_checker.sv
dv/tb_top.sv
